// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl of the letterbox viewport block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, off while reset is low
`define LVPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true out of reset
`define LVPM_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/lvpm_pkg.sv =====
// types, constants and helper functions of the letterbox viewport block
// no dependencies
package lvpm_pkg;

  localparam int SCR_W      = 14;
  localparam int SRC_W      = 13;
  localparam int POS_W      = 16;
  localparam int MAP_W      = 12;
  localparam int VIEW_W     = 15;
  localparam int QUO_W      = 14;
  localparam int DVD_W      = 26;
  localparam int DIV_STAGES = QUO_W / 2;
  localparam int VLD_N      = 3 + DIV_STAGES + 2;

  localparam logic [SCR_W-1:0] SCR_MAX   = 14'd8192;
  localparam logic [SRC_W-1:0] SRC_MAX   = 13'd4096;
  localparam logic [SRC_W-1:0] PTR_WIN_W = 13'd1024;
  localparam logic [SRC_W-1:0] PTR_WIN_H = 13'd768;

  typedef logic [2:0] cfg_idx_t;
  typedef logic [SCR_W-1:0] cfg_data_t;

  typedef enum logic [2:0] {
    CFG_SCREEN_W = 3'd0,
    CFG_SCREEN_H = 3'd1,
    CFG_SOURCE_W = 3'd2,
    CFG_SOURCE_H = 3'd3,
    CFG_FIT_MODE = 3'd4,
    CFG_PTR_WIN  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FIT_ORIGINAL = 3'd0,
    FIT_INTEGER  = 3'd1,
    FIT_ASPECT   = 3'd2,
    FIT_STRETCH  = 3'd3,
    FIT_MANUAL   = 3'd4
  } fit_mode_e;

  function automatic logic [SCR_W-1:0] clamp_scr(input logic [SCR_W-1:0] v);
    logic [SCR_W-1:0] r;
    if (v == '0) begin
      r = SCR_W'(1);
    end else if (v > SCR_MAX) begin
      r = SCR_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [SRC_W-1:0] clamp_src(input logic [SRC_W-1:0] v);
    logic [SRC_W-1:0] r;
    if (v == '0) begin
      r = SRC_W'(1);
    end else if (v > SRC_MAX) begin
      r = SRC_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // halving that truncates toward zero
  function automatic logic signed [VIEW_W-1:0] half_tz(input logic signed [VIEW_W-1:0] d);
    logic signed [VIEW_W-1:0] t;
    t = d + VIEW_W'(d[VIEW_W-1]);
    return t >>> 1;
  endfunction

  // pointer offset into the window, clamped to its first and last pixel
  function automatic logic [MAP_W-1:0] map_off(input logic signed [POS_W-1:0] pos,
                                               input logic [SCR_W-1:0] scr,
                                               input logic [SRC_W-1:0] win);
    logic signed [VIEW_W-1:0] diff;
    logic signed [VIEW_W-1:0] left;
    logic signed [POS_W:0] off;
    logic signed [POS_W:0] wins;
    logic [MAP_W-1:0] r;
    diff = signed'({1'b0, scr}) - signed'({2'b00, win});
    left = half_tz(diff);
    off  = {pos[POS_W-1], pos} - {{(POS_W+1-VIEW_W){left[VIEW_W-1]}}, left};
    wins = signed'({{(POS_W+1-SRC_W){1'b0}}, win});
    if (off < 0) begin
      r = '0;
    end else if (off >= wins) begin
      r = MAP_W'(win - SRC_W'(1));
    end else begin
      r = off[MAP_W-1:0];
    end
    return r;
  endfunction

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [SRC_W:0] div_step(input logic [SRC_W-1:0] rem,
                                              input logic nb,
                                              input logic [SRC_W-1:0] dsr);
    logic [SRC_W:0] t;
    logic [SRC_W:0] r;
    t = {rem, nb};
    if (t >= {1'b0, dsr}) begin
      t = t - {1'b0, dsr};
      r = {1'b1, t[SRC_W-1:0]};
    end else begin
      r = {1'b0, t[SRC_W-1:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/lvpm_in_if.sv =====
// input channel of the letterbox viewport block: one pointer position per item
// depends on lvpm_pkg
interface lvpm_in_if;
  import lvpm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pointer_x;
  logic signed [POS_W-1:0] pointer_y;

  modport source (output valid, output pointer_x, output pointer_y, input ready);
  modport sink   (input valid, input pointer_x, input pointer_y, output ready);
endinterface

// ===== rtl/lvpm_out_if.sv =====
// output channel of the letterbox viewport block: mapped pointer and viewport
// depends on lvpm_pkg
interface lvpm_out_if;
  import lvpm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MAP_W-1:0]         mapped_x;
  logic [MAP_W-1:0]         mapped_y;
  logic signed [VIEW_W-1:0] view_left;
  logic signed [VIEW_W-1:0] view_top;
  logic signed [VIEW_W-1:0] view_right;
  logic signed [VIEW_W-1:0] view_bottom;

  modport source (output valid, output mapped_x, output mapped_y, output view_left,
                  output view_top, output view_right, output view_bottom, input ready);
  modport sink   (input valid, input mapped_x, input mapped_y, input view_left,
                  input view_top, input view_right, input view_bottom, output ready);
endinterface

// ===== rtl/lvpm_div.sv =====
// pipelined restoring divider, two quotient bits per stage
// depends on lvpm_pkg; quotient must fit in QUO_W bits
module lvpm_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [lvpm_pkg::DVD_W-1:0]    dividend_i,
  input  logic [lvpm_pkg::SRC_W-1:0]    divisor_i,
  output logic [lvpm_pkg::QUO_W-1:0]    quotient_o
);
  import lvpm_pkg::*;

  logic [SRC_W-1:0] rem_q [DIV_STAGES];
  logic [SRC_W-1:0] rem_d [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_d [DIV_STAGES];
  logic [DVD_W-1:0] dvd_q [DIV_STAGES];
  logic [DVD_W-1:0] dvd_d [DIV_STAGES];
  logic [SRC_W-1:0] dsr_q [DIV_STAGES];
  logic [SRC_W-1:0] dsr_d [DIV_STAGES];

  always_comb begin
    logic [SRC_W-1:0] r;
    logic [QUO_W-1:0] q;
    logic [DVD_W-1:0] dv;
    logic [SRC_W-1:0] d;
    logic [SRC_W:0]   t;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        r  = SRC_W'(dividend_i[DVD_W-1:QUO_W]);
        q  = '0;
        dv = dividend_i;
        d  = divisor_i;
      end else begin
        r  = rem_q[s-1];
        q  = quo_q[s-1];
        dv = dvd_q[s-1];
        d  = dsr_q[s-1];
      end
      t = div_step(r, dv[QUO_W-1-2*s], d);
      r = t[SRC_W-1:0];
      q[QUO_W-1-2*s] = t[SRC_W];
      t = div_step(r, dv[QUO_W-2-2*s], d);
      r = t[SRC_W-1:0];
      q[QUO_W-2-2*s] = t[SRC_W];
      rem_d[s] = r;
      quo_d[s] = q;
      dvd_d[s] = dv;
      dsr_d[s] = d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      dvd_q <= dvd_d;
      dsr_q <= dsr_d;
    end
  end

  assign quotient_o = quo_q[DIV_STAGES-1];

endmodule

// ===== rtl/letterbox_viewport_pointer_map.sv =====
// channel  dir  fields                                    handshake
// in_ch    in   pointer_x, pointer_y                      valid/ready
// out_ch   out  mapped_x/y, view_left/top/right/bottom    valid/ready
// cfg      in   cfg_idx_i, cfg_data_i                     cfg_we_i, no wait
//
// twelve register stages from input to output register: offset, products,
// select, seven divider stages, scale, viewport
// one item per cycle; the slowest stage is one 14 bit divide step pair or one multiply
// the whole pipeline holds while the output register is full and not taken
// reset loads the default configuration and empties the pipeline
// depends on lvpm_pkg, lvpm_in_if, lvpm_out_if, lvpm_div, assert_macros.svh
module letterbox_viewport_pointer_map (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  lvpm_pkg::cfg_idx_t       cfg_idx_i,
  input  lvpm_pkg::cfg_data_t      cfg_data_i,
  lvpm_in_if.sink                  in_ch,
  lvpm_out_if.source               out_ch
);
  import lvpm_pkg::*;
  `include "assert_macros.svh"

  logic [SCR_W-1:0] scr_w_q, scr_h_q;
  logic [SRC_W-1:0] src_w_q, src_h_q;
  logic [2:0]       fit_q;
  logic             pwl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= 14'd640;
      scr_h_q <= 14'd480;
      src_w_q <= 13'd640;
      src_h_q <= 13'd480;
      fit_q   <= FIT_ASPECT;
      pwl_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SCREEN_W: scr_w_q <= cfg_data_i;
        CFG_SCREEN_H: scr_h_q <= cfg_data_i;
        CFG_SOURCE_W: src_w_q <= cfg_data_i[SRC_W-1:0];
        CFG_SOURCE_H: src_h_q <= cfg_data_i[SRC_W-1:0];
        CFG_FIT_MODE: fit_q   <= cfg_data_i[2:0];
        CFG_PTR_WIN:  pwl_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective sizes and pointer window; user: static while items in flight, unenforced
  logic [SCR_W-1:0] sw, sh;
  logic [SRC_W-1:0] w, h, cw, ch;
  logic             fixed_win;

  always_comb begin
    sw        = clamp_scr(scr_w_q);
    sh        = clamp_scr(scr_h_q);
    w         = clamp_src(src_w_q);
    h         = clamp_src(src_h_q);
    fixed_win = pwl_q && (sw >= SCR_W'(PTR_WIN_W)) && (sh >= SCR_W'(PTR_WIN_H));
    cw        = fixed_win ? PTR_WIN_W : w;
    ch        = fixed_win ? PTR_WIN_H : h;
  end

  logic [VLD_N-1:0] vld_q;
  logic             en;

  assign en          = !vld_q[VLD_N-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[VLD_N-2:0], in_ch.valid};
    end
  end

  // stage 1: clamped offsets
  logic [MAP_W-1:0] offx_q, offy_q;
  // stage 2: products
  logic [DVD_W-2:0] px_q, py_q;
  logic [DVD_W-1:0] swh_q, shw_q;
  // stage 3: divider operands
  logic [DVD_W-1:0] fdvd_q;
  logic [SRC_W-1:0] fdsr_q;
  logic [DVD_W-1:0] mxd_q, myd_q;
  logic             ovf3_q;
  logic             ovf_q [DIV_STAGES];
  logic [DVD_W-1:0] b;
  logic             ovf;

  assign b   = shw_q + DVD_W'(w);
  assign ovf = swh_q >= b;

  always_ff @(posedge clk_i) begin
    if (en) begin
      offx_q <= map_off(in_ch.pointer_x, sw, cw);
      offy_q <= map_off(in_ch.pointer_y, sh, ch);
      px_q   <= (DVD_W-1)'(offx_q) * (DVD_W-1)'(w);
      py_q   <= (DVD_W-1)'(offy_q) * (DVD_W-1)'(h);
      swh_q  <= DVD_W'(sw) * DVD_W'(h);
      shw_q  <= DVD_W'(sh) * DVD_W'(w);
      ovf3_q <= ovf;
      fdvd_q <= ovf ? shw_q : swh_q;
      fdsr_q <= ovf ? h : w;
      mxd_q  <= DVD_W'(px_q);
      myd_q  <= DVD_W'(py_q);
      ovf_q[0] <= ovf3_q;
      for (int s = 1; s < DIV_STAGES; s++) begin
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  logic [QUO_W-1:0] qmx, qmy, qkx, qky, qfit;

  lvpm_div u_div_mx (.clk_i, .en_i(en), .dividend_i(mxd_q), .divisor_i(cw), .quotient_o(qmx));
  lvpm_div u_div_my (.clk_i, .en_i(en), .dividend_i(myd_q), .divisor_i(ch), .quotient_o(qmy));
  lvpm_div u_div_kx (.clk_i, .en_i(en), .dividend_i(DVD_W'(sw)), .divisor_i(w),
                     .quotient_o(qkx));
  lvpm_div u_div_ky (.clk_i, .en_i(en), .dividend_i(DVD_W'(sh)), .divisor_i(h),
                     .quotient_o(qky));
  lvpm_div u_div_fit (.clk_i, .en_i(en), .dividend_i(fdvd_q), .divisor_i(fdsr_q),
                      .quotient_o(qfit));

  // scale stage
  logic [QUO_W-1:0] k;
  logic [SCR_W-1:0] vwi_q, vhi_q, vwa_q, vha_q;
  logic [MAP_W-1:0] mx_q, my_q;
  logic [2*QUO_W-1:0] vwi_p, vhi_p;

  assign k     = (qkx < qky) ? qkx : qky;
  assign vwi_p = (2*QUO_W)'(w) * (2*QUO_W)'(k);
  assign vhi_p = (2*QUO_W)'(h) * (2*QUO_W)'(k);

  always_ff @(posedge clk_i) begin
    if (en) begin
      vwi_q <= vwi_p[SCR_W-1:0];
      vhi_q <= vhi_p[SCR_W-1:0];
      vwa_q <= ovf_q[DIV_STAGES-1] ? qfit[SCR_W-1:0] : sw;
      vha_q <= ovf_q[DIV_STAGES-1] ? sh : qfit[SCR_W-1:0];
      mx_q  <= qmx[MAP_W-1:0];
      my_q  <= qmy[MAP_W-1:0];
    end
  end

  // viewport stage, output register
  logic [SCR_W-1:0] vw, vh;
  logic signed [VIEW_W-1:0] x1, y1;

  always_comb begin
    unique case (fit_mode_e'(fit_q))
      FIT_ORIGINAL: begin
        vw = SCR_W'(w);
        vh = SCR_W'(h);
      end
      FIT_INTEGER: begin
        vw = vwi_q;
        vh = vhi_q;
      end
      FIT_ASPECT: begin
        vw = vwa_q;
        vh = vha_q;
      end
      default: begin
        vw = sw;
        vh = sh;
      end
    endcase
    x1 = half_tz(signed'({1'b0, sw}) - signed'({1'b0, vw}));
    y1 = half_tz(signed'({1'b0, sh}) - signed'({1'b0, vh}));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_ch.mapped_x    <= mx_q;
      out_ch.mapped_y    <= my_q;
      out_ch.view_left   <= x1;
      out_ch.view_top    <= y1;
      out_ch.view_right  <= x1 + signed'({1'b0, vw});
      out_ch.view_bottom <= y1 + signed'({1'b0, vh});
    end
  end

  assign out_ch.valid = vld_q[VLD_N-1];

  `LVPM_ASSERT(a_rect_order, clk_i, rst_ni, out_ch.valid |-> (out_ch.view_right >= out_ch.view_left && out_ch.view_bottom >= out_ch.view_top), "viewport edges out of order")
  `LVPM_ASSERT(a_map_range, clk_i, rst_ni, out_ch.valid |-> (SRC_W'(out_ch.mapped_x) < w && SRC_W'(out_ch.mapped_y) < h), "mapped pointer beyond source size")
  `LVPM_ASSERT(a_aspect_fit, clk_i, rst_ni, vld_q[VLD_N-2] |-> (vwa_q <= sw && vha_q <= sh), "aspect fit exceeds screen")
  `LVPM_NEVER(a_stall_drop, clk_i, rst_ni, $past(out_ch.valid && !out_ch.ready) && !out_ch.valid, "item dropped under stall")

endmodule
